[hw/rtl/sgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_pkg
// Shared widths, register indexes, status codes and stage types of the
// sprite grid crop rectangle generator.
// ----------------------------------------------------------------------------
package sgc_pkg;

    localparam int unsigned COORD_W    = 16;
    localparam int unsigned GRID_W     = 8;
    localparam int unsigned PART_W     = 12;
    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned USE_W      = 22;  // signed usable size
    localparam int unsigned SPC_W      = 20;  // spacing times cell count
    localparam int unsigned STEP_W     = 17;  // frame size plus spacing
    localparam int unsigned MUL_W      = 25;  // step times cell count
    localparam int unsigned FAR_W      = 26;  // far cell edge
    localparam int unsigned DIV_STAGES = COORD_W;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_MAJOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MARGINS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_FRAME  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES   = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_AREA  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNEVEN   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OOB      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_BEYOND   = 3'd7;

    typedef struct packed {
        logic [GRID_W-1:0]  rows;
        logic [GRID_W-1:0]  cols;
        logic               column_major;
        logic [PART_W-1:0]  ml;
        logic [PART_W-1:0]  mt;
        logic [PART_W-1:0]  mr;
        logic [PART_W-1:0]  mb;
        logic [PART_W-1:0]  sx;
        logic [PART_W-1:0]  sy;
        logic [PART_W-1:0]  ow;
        logic [PART_W-1:0]  oh;
        logic [COORD_W-1:0] start_frame;
        logic [COORD_W-1:0] max_frames;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic zgrid;
        logic noarea;
        logic uneven;
        logic none;
        logic beyond;
    } t_flags;

    typedef struct packed {
        logic               v;
        t_flags             f;
        logic [COORD_W-1:0] sw;
        logic [COORD_W-1:0] sh;
        logic [COORD_W-1:0] count;
        logic [COORD_W-1:0] idx;
    } t_side;

    typedef struct packed {
        t_side              s;
        logic [COORD_W-1:0] fw;
        logic [COORD_W-1:0] fh;
        logic [STEP_W-1:0]  stepx;
        logic [STEP_W-1:0]  stepy;
        logic [GRID_W-1:0]  row;
        logic [GRID_W-1:0]  col;
    } t_geo;

    typedef struct packed {
        t_side              s;
        logic [COORD_W-1:0] fw;
        logic [COORD_W-1:0] fh;
        logic [MUL_W-1:0]   farx;
        logic [MUL_W-1:0]   fary;
        logic [MUL_W-1:0]   offx;
        logic [MUL_W-1:0]   offy;
    } t_mul;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  w;
        logic [COORD_W-1:0]  h;
        logic [COORD_W-1:0]  cell_idx;
        logic [COORD_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_res;

endpackage

[hw/rtl/sgc_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_cfg_regs
// Configuration register file; unpacks the packed fields for the datapath.
// ----------------------------------------------------------------------------
module sgc_cfg_regs
    import sgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg cfg_rst;

    // register defaults: one row, one column, everything else zero
    always_comb begin
        cfg_rst      = '0;
        cfg_rst.rows = GRID_W'(1);
        cfg_rst.cols = GRID_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cfg_rst;
        end else if (i_we) begin
            case (i_index)
                REG_GRID_ROWS:    r_cfg.rows         <= i_data[GRID_W-1:0];
                REG_GRID_COLUMNS: r_cfg.cols         <= i_data[GRID_W-1:0];
                REG_COLUMN_MAJOR: r_cfg.column_major <= i_data[0];
                REG_MARGINS: begin
                    r_cfg.ml <= i_data[11:0];
                    r_cfg.mt <= i_data[23:12];
                    r_cfg.mr <= i_data[35:24];
                    r_cfg.mb <= i_data[47:36];
                end
                REG_SPACING: begin
                    r_cfg.sx <= i_data[11:0];
                    r_cfg.sy <= i_data[23:12];
                end
                REG_FRAME_SIZE: begin
                    r_cfg.ow <= i_data[11:0];
                    r_cfg.oh <= i_data[23:12];
                end
                REG_START_FRAME:  r_cfg.start_frame <= i_data[COORD_W-1:0];
                REG_MAX_FRAMES:   r_cfg.max_frames  <= i_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/sgc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_div
// Pipelined restoring divider: one quotient bit per stage, DW stages.
// ----------------------------------------------------------------------------
module sgc_div #(
    parameter int unsigned DW = 16,
    parameter int unsigned VW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    logic [DW-1:0] r_dq [DW];
    logic [VW-1:0] r_rm [DW];
    logic [VW-1:0] r_dv [DW-1];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [DW-1:0] dq_in;
        logic [VW-1:0] rm_in;
        logic [VW-1:0] dv_in;
        logic [VW:0]   trial;
        logic [VW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign dq_in = i_dividend;
            assign rm_in = '0;
            assign dv_in = i_divisor;
        end else begin : g_next
            assign dq_in = r_dq[k-1];
            assign rm_in = r_rm[k-1];
            assign dv_in = r_dv[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign trial = {rm_in, dq_in[DW-1]};
        assign ge    = trial >= {1'b0, dv_in};
        assign diff  = trial - {1'b0, dv_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[k] <= {dq_in[DW-2:0], ge};
                r_rm[k] <= ge ? diff[VW-1:0] : trial[VW-1:0];
            end
        end

        if (k < DW - 1) begin : g_dv
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv[k] <= dv_in;
                end
            end
        end
    end

    assign o_quot = r_dq[DW-1];
    assign o_rem  = r_rm[DW-1];

endmodule

[hw/rtl/sprite_grid_crop_rect_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_grid_crop_rect_generator_unit
// Crop rectangle, cell index, frame count and status of one grid cell.
// ----------------------------------------------------------------------------
// Registers in order: input, range, 16-stage dividers, frame size, offsets, output.
// Throughput: one item per cycle while the skid register is empty.
// A result not taken holds the pipeline; a skid register lets one more item
// finish behind it. Reset clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module sprite_grid_crop_rect_generator_unit
    import sgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_W-1:0]    i_sheet_width,
    input  logic [COORD_W-1:0]    i_sheet_height,
    input  logic [COORD_W-1:0]    i_position,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_W-1:0]    o_crop_x,
    output logic [COORD_W-1:0]    o_crop_y,
    output logic [COORD_W-1:0]    o_crop_width,
    output logic [COORD_W-1:0]    o_crop_height,
    output logic [COORD_W-1:0]    o_cell_index,
    output logic [COORD_W-1:0]    o_frame_count,
    output logic [STATUS_W-1:0]   o_status
);

    t_cfg cfg;
    logic en;

    sgc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // cell count minus one, shared by usable size and far-cell checks
    logic [GRID_W-1:0] cm1;
    logic [GRID_W-1:0] rm1;
    assign cm1 = cfg.cols - GRID_W'(1);
    assign rm1 = cfg.rows - GRID_W'(1);

    // ---------------- stage A: input register ----------------
    logic               r_a_v;
    logic [COORD_W-1:0] r_a_sw;
    logic [COORD_W-1:0] r_a_sh;
    logic [COORD_W-1:0] r_a_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sw  <= i_sheet_width;
            r_a_sh  <= i_sheet_height;
            r_a_pos <= i_position;
        end
    end

    // usable size, frame range and cell index
    logic [SPC_W-1:0]   spx;
    logic [SPC_W-1:0]   spy;
    logic [USE_W-1:0]   n_uw;
    logic [USE_W-1:0]   n_uh;
    logic [COORD_W-1:0] total;
    logic [COORD_W-1:0] start;
    logic [COORD_W-1:0] avail;
    logic [COORD_W-1:0] count;
    logic [COORD_W:0]   idx_sum;
    t_side              n_b;

    assign spx   = SPC_W'(cfg.sx) * SPC_W'(cm1);
    assign spy   = SPC_W'(cfg.sy) * SPC_W'(rm1);
    assign n_uw  = USE_W'(r_a_sw) - USE_W'(cfg.ml) - USE_W'(cfg.mr) - USE_W'(spx);
    assign n_uh  = USE_W'(r_a_sh) - USE_W'(cfg.mt) - USE_W'(cfg.mb) - USE_W'(spy);
    assign total = COORD_W'(cfg.rows) * COORD_W'(cfg.cols);
    assign start = (cfg.start_frame < total) ? cfg.start_frame : total;
    assign avail = total - start;
    assign count = (cfg.max_frames != '0 && cfg.max_frames < avail) ?
                   cfg.max_frames : avail;
    assign idx_sum = {1'b0, start} + {1'b0, r_a_pos};

    always_comb begin
        n_b          = '0;
        n_b.v        = r_a_v;
        n_b.f.empty  = (r_a_sw == '0) || (r_a_sh == '0);
        n_b.f.zgrid  = (cfg.rows == '0) || (cfg.cols == '0);
        n_b.f.none   = (count == '0);
        n_b.f.beyond = (r_a_pos >= count);
        n_b.sw       = r_a_sw;
        n_b.sh       = r_a_sh;
        n_b.count    = count;
        n_b.idx      = idx_sum[COORD_W-1:0];
    end

    // ---------------- stage B: range register ----------------
    t_side            r_b;
    logic [USE_W-1:0] r_b_uw;
    logic [USE_W-1:0] r_b_uh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.v <= 1'b0;
        end else if (en) begin
            r_b    <= n_b;
            r_b_uw <= n_uw;
            r_b_uh <= n_uh;
        end
    end

    // no usable area when either size is zero or negative
    t_side             n_side;
    logic [GRID_W-1:0] idx_div;

    always_comb begin
        n_side          = r_b;
        n_side.f.noarea = r_b_uw[USE_W-1] || (r_b_uw == '0) ||
                          r_b_uh[USE_W-1] || (r_b_uh == '0);
    end

    assign idx_div = cfg.column_major ? cfg.rows : cfg.cols;

    // ---------------- divider pipelines ----------------
    logic [COORD_W-1:0] qw, qh, qi;
    logic [GRID_W-1:0]  rw, rh, ri;

    sgc_div #(.DW(COORD_W), .VW(GRID_W)) u_div_w (
        .i_clk(i_clk), .i_en(en), .i_dividend(r_b_uw[COORD_W-1:0]),
        .i_divisor(cfg.cols), .o_quot(qw), .o_rem(rw)
    );

    sgc_div #(.DW(COORD_W), .VW(GRID_W)) u_div_h (
        .i_clk(i_clk), .i_en(en), .i_dividend(r_b_uh[COORD_W-1:0]),
        .i_divisor(cfg.rows), .o_quot(qh), .o_rem(rh)
    );

    sgc_div #(.DW(COORD_W), .VW(GRID_W)) u_div_i (
        .i_clk(i_clk), .i_en(en), .i_dividend(r_b.idx),
        .i_divisor(idx_div), .o_quot(qi), .o_rem(ri)
    );

    // carry the rest of the item alongside the dividers
    t_side r_sb [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_sb[k].v <= 1'b0;
            end
        end else if (en) begin
            r_sb[0] <= n_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // ---------------- stage C: frame size and cell position ----------------
    t_geo n_e;

    always_comb begin
        n_e            = '0;
        n_e.s          = r_sb[DIV_STAGES-1];
        n_e.s.f.uneven = ((rw != '0) || (rh != '0)) &&
                         ((cfg.ow == '0) || (cfg.oh == '0));
        n_e.fw         = (cfg.ow != '0) ? COORD_W'(cfg.ow) : qw;
        n_e.fh         = (cfg.oh != '0) ? COORD_W'(cfg.oh) : qh;
        n_e.stepx      = STEP_W'(n_e.fw) + STEP_W'(cfg.sx);
        n_e.stepy      = STEP_W'(n_e.fh) + STEP_W'(cfg.sy);
        if (cfg.column_major) begin
            n_e.col = qi[GRID_W-1:0];
            n_e.row = ri;
        end else begin
            n_e.row = qi[GRID_W-1:0];
            n_e.col = ri;
        end
    end

    t_geo r_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.s.v <= 1'b0;
        end else if (en) begin
            r_e <= n_e;
        end
    end

    // ---------------- stage E: offsets ----------------
    t_mul n_f;

    always_comb begin
        n_f.s    = r_e.s;
        n_f.fw   = r_e.fw;
        n_f.fh   = r_e.fh;
        n_f.farx = MUL_W'(r_e.stepx) * MUL_W'(cm1);
        n_f.fary = MUL_W'(r_e.stepy) * MUL_W'(rm1);
        n_f.offx = MUL_W'(r_e.stepx) * MUL_W'(r_e.col);
        n_f.offy = MUL_W'(r_e.stepy) * MUL_W'(r_e.row);
    end

    t_mul r_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f.s.v <= 1'b0;
        end else if (en) begin
            r_f <= n_f;
        end
    end

    // ---------------- stage F: bounds check and status ----------------
    logic [FAR_W-1:0] far_x;
    logic [FAR_W-1:0] far_y;
    logic             oob;
    t_res             n_res;

    assign far_x = FAR_W'(cfg.ml) + FAR_W'(r_f.farx) + FAR_W'(r_f.fw);
    assign far_y = FAR_W'(cfg.mt) + FAR_W'(r_f.fary) + FAR_W'(r_f.fh);
    assign oob   = (far_x > FAR_W'(r_f.s.sw)) || (far_y > FAR_W'(r_f.s.sh));

    // errors zero every field; position beyond keeps the frame count
    always_comb begin
        n_res = '0;
        if (r_f.s.f.empty) begin
            n_res.status = ST_EMPTY;
        end else if (r_f.s.f.zgrid) begin
            n_res.status = ST_ZERO;
        end else if (r_f.s.f.noarea) begin
            n_res.status = ST_NO_AREA;
        end else if (r_f.s.f.uneven) begin
            n_res.status = ST_UNEVEN;
        end else if (oob) begin
            n_res.status = ST_OOB;
        end else if (r_f.s.f.none) begin
            n_res.status = ST_NONE;
        end else if (r_f.s.f.beyond) begin
            n_res.status = ST_BEYOND;
            n_res.count  = r_f.s.count;
        end else begin
            n_res.status   = ST_OK;
            n_res.x        = COORD_W'(cfg.ml) + r_f.offx[COORD_W-1:0];
            n_res.y        = COORD_W'(cfg.mt) + r_f.offy[COORD_W-1:0];
            n_res.w        = r_f.fw;
            n_res.h        = r_f.fh;
            n_res.cell_idx = r_f.s.idx;
            n_res.count    = r_f.s.count;
        end
    end

    // ---------------- output register and skid ----------------
    logic r_ov;
    logic r_sv;
    t_res r_out;
    t_res r_skid;
    logic push;
    logic take;

    // hold the whole pipeline only once the skid register is occupied
    assign en      = !r_sv;
    assign o_ready = en;
    assign push    = r_f.s.v && en;
    assign take    = r_ov && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            // drain the skid into the output once the waiting result goes
            if (take) begin
                r_out <= r_skid;
                r_sv  <= 1'b0;
            end
        end else if (push) begin
            if (!r_ov || take) begin
                r_out <= n_res;
                r_ov  <= 1'b1;
            end else begin
                r_skid <= n_res;
                r_sv   <= 1'b1;
            end
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid       = r_ov;
    assign o_crop_x      = r_out.x;
    assign o_crop_y      = r_out.y;
    assign o_crop_width  = r_out.w;
    assign o_crop_height = r_out.h;
    assign o_cell_index  = r_out.cell_idx;
    assign o_frame_count = r_out.count;
    assign o_status      = r_out.status;

endmodule

[hw/rtl/sgc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgc_checker
// Port-level checks of result consistency and output handshake.
// ----------------------------------------------------------------------------
module sgc_checker
    import sgc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [COORD_W-1:0]    o_crop_x,
    input logic [COORD_W-1:0]    o_crop_y,
    input logic [COORD_W-1:0]    o_crop_width,
    input logic [COORD_W-1:0]    o_crop_height,
    input logic [COORD_W-1:0]    o_cell_index,
    input logic [COORD_W-1:0]    o_frame_count,
    input logic [STATUS_W-1:0]   o_status
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |->
            o_crop_width != '0 && o_crop_height != '0 && o_frame_count != '0)
        else $error("ok result with empty frame or range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK && o_status != ST_BEYOND |->
            o_crop_x == '0 && o_crop_y == '0 && o_crop_width == '0 &&
            o_crop_height == '0 && o_cell_index == '0 && o_frame_count == '0)
        else $error("error result carries nonzero fields");

    a_beyond_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_BEYOND |->
            o_frame_count != '0 && o_cell_index == '0 && o_crop_width == '0)
        else $error("position beyond result malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) &&
            $stable(o_crop_x) && $stable(o_cell_index))
        else $error("stalled result changed");

endmodule

bind sprite_grid_crop_rect_generator_unit sgc_checker u_sgc_checker (.*);

[verif/crop_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crop_checker
// Watches the configuration port and both channels of the crop rectangle
// generator, predicts each result from its own register copy and compares.
// ----------------------------------------------------------------------------
module crop_checker
    import sgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [COORD_W-1:0]    i_sheet_width,
    input  logic [COORD_W-1:0]    i_sheet_height,
    input  logic [COORD_W-1:0]    i_position,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_res                  i_result,
    output int                    o_fail_count,
    output int                    o_pending
);

    t_cfg grid_regs;
    t_res expected_rects[$];
    int   mismatches = 0;

    function automatic t_res crop_of(t_cfg c, logic [COORD_W-1:0] sw_in,
                                     logic [COORD_W-1:0] sh_in,
                                     logic [COORD_W-1:0] pos_in);
        longint sw, sh, pos, rows, cols, uw, uh, fw, fh, cells, first, avail, cnt;
        longint idx, row, col;
        t_res r;
        sw   = longint'(sw_in);
        sh   = longint'(sh_in);
        pos  = longint'(pos_in);
        rows = longint'(c.rows);
        cols = longint'(c.cols);
        r    = '0;
        if (sw == 0 || sh == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        if (rows == 0 || cols == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        uw = sw - longint'(c.ml) - longint'(c.mr) - longint'(c.sx) * (cols - 1);
        uh = sh - longint'(c.mt) - longint'(c.mb) - longint'(c.sy) * (rows - 1);
        if (uw <= 0 || uh <= 0) begin
            r.status = ST_NO_AREA;
            return r;
        end
        if ((uw % cols != 0 || uh % rows != 0) && (c.ow == 0 || c.oh == 0)) begin
            r.status = ST_UNEVEN;
            return r;
        end
        fw = (c.ow != 0) ? longint'(c.ow) : uw / cols;
        fh = (c.oh != 0) ? longint'(c.oh) : uh / rows;
        // far cell bounds cover every cell
        if (longint'(c.ml) + (cols - 1) * (fw + longint'(c.sx)) + fw > sw ||
            longint'(c.mt) + (rows - 1) * (fh + longint'(c.sy)) + fh > sh) begin
            r.status = ST_OOB;
            return r;
        end
        cells = rows * cols;
        first = (longint'(c.start_frame) < cells) ? longint'(c.start_frame) : cells;
        avail = cells - first;
        cnt   = (c.max_frames != 0 && longint'(c.max_frames) < avail) ?
                longint'(c.max_frames) : avail;
        if (cnt == 0) begin
            r.status = ST_NONE;
            return r;
        end
        if (pos >= cnt) begin
            r.count  = cnt[COORD_W-1:0];
            r.status = ST_BEYOND;
            return r;
        end
        idx = first + pos;
        if (c.column_major) begin
            col = idx / rows;
            row = idx % rows;
        end else begin
            row = idx / cols;
            col = idx % cols;
        end
        r.x        = COORD_W'(longint'(c.ml) + col * (fw + longint'(c.sx)));
        r.y        = COORD_W'(longint'(c.mt) + row * (fh + longint'(c.sy)));
        r.w        = COORD_W'(fw);
        r.h        = COORD_W'(fh);
        r.cell_idx = COORD_W'(idx);
        r.count    = COORD_W'(cnt);
        r.status   = ST_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        t_cfg rst_cfg;
        if (!i_rst_n) begin
            rst_cfg      = '0;
            rst_cfg.rows = GRID_W'(1);
            rst_cfg.cols = GRID_W'(1);
            grid_regs   <= rst_cfg;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GRID_ROWS:    grid_regs.rows         <= i_cfg_data[GRID_W-1:0];
                    REG_GRID_COLUMNS: grid_regs.cols         <= i_cfg_data[GRID_W-1:0];
                    REG_COLUMN_MAJOR: grid_regs.column_major <= i_cfg_data[0];
                    REG_MARGINS: begin
                        grid_regs.ml <= i_cfg_data[11:0];
                        grid_regs.mt <= i_cfg_data[23:12];
                        grid_regs.mr <= i_cfg_data[35:24];
                        grid_regs.mb <= i_cfg_data[47:36];
                    end
                    REG_SPACING: begin
                        grid_regs.sx <= i_cfg_data[11:0];
                        grid_regs.sy <= i_cfg_data[23:12];
                    end
                    REG_FRAME_SIZE: begin
                        grid_regs.ow <= i_cfg_data[11:0];
                        grid_regs.oh <= i_cfg_data[23:12];
                    end
                    REG_START_FRAME:  grid_regs.start_frame <= i_cfg_data[COORD_W-1:0];
                    REG_MAX_FRAMES:   grid_regs.max_frames  <= i_cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_rects.push_back(crop_of(grid_regs, i_sheet_width,
                                                 i_sheet_height, i_position));
            if (i_out_valid && i_out_ready) begin
                if (expected_rects.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t unexpected result %p", $realtime, i_result);
                end else begin
                    want = expected_rects.pop_front();
                    if (i_result !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%t result differs: expected %p actual %p",
                                     $realtime, want, i_result);
                    end
                end
            end
        end
    end

    assign o_fail_count = mismatches;
    assign o_pending    = expected_rects.size();

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sheet sizes and positions into the crop rectangle generator under
// a series of grid settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import sgc_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [COORD_W-1:0]    sheet_width;
    logic [COORD_W-1:0]    sheet_height;
    logic [COORD_W-1:0]    position;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_res                  result;
    int                    fail_count;
    int                    pending;

    // idle percentages of each side; a toggle of hold_kick asks for a long stall
    int tx_idle;
    int rx_idle;
    bit hold_kick;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    // shadow of the grid registers used to build well-formed sheets
    int rows, cols, ml, mt, mr, mb, sx, sy, ow, oh;

    sprite_grid_crop_rect_generator_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_sheet_width  (sheet_width),
        .i_sheet_height (sheet_height),
        .i_position     (position),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_crop_x       (result.x),
        .o_crop_y       (result.y),
        .o_crop_width   (result.w),
        .o_crop_height  (result.h),
        .o_cell_index   (result.cell_idx),
        .o_frame_count  (result.count),
        .o_status       (result.status)
    );

    crop_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_sheet_width  (sheet_width),
        .i_sheet_height (sheet_height),
        .i_position     (position),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_result       (result),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Result side: random stalls, or a long hold-off when asked.
    always @(posedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= 400;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Offer one item and return at the edge that takes it.
    task automatic send(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                        input logic [COORD_W-1:0] p);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle && gap < 20)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        sheet_width  <= w;
        sheet_height <= h;
        position     <= p;
        forever begin
            @(negedge i_clk);
            if (in_ready) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected result is back.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_GRID_ROWS:    rows = int'(data[7:0]);
            REG_GRID_COLUMNS: cols = int'(data[7:0]);
            REG_MARGINS: begin
                ml = int'(data[11:0]);
                mt = int'(data[23:12]);
                mr = int'(data[35:24]);
                mb = int'(data[47:36]);
            end
            REG_SPACING: begin
                sx = int'(data[11:0]);
                sy = int'(data[23:12]);
            end
            REG_FRAME_SIZE: begin
                ow = int'(data[11:0]);
                oh = int'(data[23:12]);
            end
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand48();
        return CFG_DATA_W'({$urandom(), $urandom()});
    endfunction

    // Small part most of the time, full 12-bit range now and then.
    function automatic int pick_part(int lim);
        return ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(lim);
    endfunction

    // Pick a random grid setting; upper data bits are random to exercise masking.
    task automatic random_grid();
        logic [CFG_DATA_W-1:0] d;
        d = rand48();
        d[7:0] = 8'(($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(1, 8));
        write_reg(REG_GRID_ROWS, d);
        d = rand48();
        d[7:0] = 8'(($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(1, 8));
        write_reg(REG_GRID_COLUMNS, d);
        write_reg(REG_COLUMN_MAJOR, rand48());
        write_reg(REG_MARGINS, {12'(pick_part(20)), 12'(pick_part(20)),
                                12'(pick_part(20)), 12'(pick_part(20))});
        d = rand48();
        d[23:0] = {12'(pick_part(6)), 12'(pick_part(6))};
        write_reg(REG_SPACING, d);
        d = rand48();
        if ($urandom_range(2) != 0)
            d[23:0] = '0;
        else
            d[23:0] = {12'($urandom_range(0, 40)), 12'($urandom_range(0, 40))};
        write_reg(REG_FRAME_SIZE, d);
        d = rand48();
        if ($urandom_range(3) != 0)
            d[15:0] = 16'($urandom_range(6));
        write_reg(REG_START_FRAME, d);
        d = rand48();
        if ($urandom_range(3) != 0)
            d[15:0] = 16'($urandom_range(10));
        write_reg(REG_MAX_FRAMES, d);
        end_writes();
    endtask

    // Mostly sheets that fit the grid exactly; some off by a little, some noise.
    task automatic random_item();
        int fw, fh, w, h, p, kind;
        kind = $urandom_range(99);
        fw = (ow != 0) ? ow : $urandom_range(1, 40);
        fh = (oh != 0) ? oh : $urandom_range(1, 40);
        w  = ml + mr + sx * (cols - 1) + fw * cols;
        h  = mt + mb + sy * (rows - 1) + fh * rows;
        if (kind < 20) begin
            w += $urandom_range(3) - 1;
            h += $urandom_range(3) - 1;
        end
        if (w < 0 || w > 65535) w = $urandom_range(65535);
        if (h < 0 || h > 65535) h = $urandom_range(65535);
        p = $urandom_range(0, rows * cols + 1);
        if (kind >= 90)
            send(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                 16'($urandom_range(65535)));
        else
            send(16'(w), 16'(h), 16'(p));
    endtask

    initial begin
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sheet_width  = '0;
        sheet_height = '0;
        position     = '0;
        hold_kick = 1'b0;
        tx_idle   = 16;
        rx_idle   = 60;
        rows = 1; cols = 1; ml = 0; mt = 0; mr = 0; mb = 0;
        sx = 0; sy = 0; ow = 0; oh = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset grid, empty sheet, full sheet, position past the range.
        send(16'd0, 16'd100, 16'd0);
        send(16'd100, 16'd0, 16'd0);
        send(16'hFFFF, 16'hFFFF, 16'd0);
        send(16'hFFFF, 16'hFFFF, 16'd1);
        send(16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();
        write_reg(REG_GRID_ROWS, '0);
        end_writes();
        send(16'd64, 16'd64, 16'd0);                 // zero grid
        drain();
        write_reg(REG_GRID_ROWS, 48'd3);
        write_reg(REG_GRID_COLUMNS, 48'd4);
        write_reg(REG_MARGINS, {12'd2, 12'd2, 12'd1, 12'd1});
        write_reg(REG_SPACING, {12'd1, 12'd1});
        end_writes();
        send(16'd8, 16'd40, 16'd0);                  // uneven split, usable width too narrow
        send(16'd45, 16'd40, 16'd0);                 // uneven split
        send(16'd46, 16'd38, 16'd5);                 // exact fit, ok
        send(16'd46, 16'd38, 16'd11);                // last cell
        send(16'd46, 16'd38, 16'd12);                // position beyond
        drain();
        write_reg(REG_COLUMN_MAJOR, 48'd1);
        write_reg(REG_FRAME_SIZE, {12'd30, 12'd30});
        end_writes();
        send(16'd46, 16'd38, 16'd3);                 // override leaves the sheet
        send(16'd200, 16'd200, 16'd7);               // column-major with override
        drain();
        write_reg(REG_START_FRAME, 48'hFFFF);
        end_writes();
        send(16'd200, 16'd200, 16'd0);               // empty range
        drain();
        write_reg(REG_START_FRAME, 48'd10);
        write_reg(REG_MAX_FRAMES, 48'hFFFF);
        end_writes();
        send(16'd200, 16'd200, 16'd1);
        send(16'd200, 16'd200, 16'd2);
        drain();
        // Extremes: every register but the column-major flag at its top value.
        write_reg(REG_GRID_ROWS, '1);
        write_reg(REG_GRID_COLUMNS, '1);
        write_reg(REG_MARGINS, '1);
        write_reg(REG_SPACING, '1);
        write_reg(REG_FRAME_SIZE, '1);
        write_reg(REG_START_FRAME, '1);
        write_reg(REG_MAX_FRAMES, '1);
        end_writes();
        send(16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();

        // Random phases: idling pattern changes across the three thirds.
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                tx_idle = 60;
                rx_idle = 16;
            end else if (ph == 6) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            random_grid();
            for (int n = 0; n < 155; n++) begin
                if (ph == 7 && n == 20)
                    hold_kick = ~hold_kick;          // long result-side stall
                if (ph == 4 && n == 80) begin
                    in_valid <= 1'b0;                // pause until all results return
                    while (pending != 0)
                        @(posedge i_clk);
                end
                random_item();
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
